@@ rtl/kwcd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package kwcd_pkg;

    localparam int SAMPLE_W     = 12;
    localparam int KNOB_IDX_W   = 2;
    localparam int IN_FIELDS    = 3;
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 16;

    localparam logic [SAMPLE_W-1:0] THRESH_RESET = 12'd20;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr_en;     // store the incoming word at the window position
        logic rd_en;     // read one window row
        logic rd_first;  // the row being read is row zero
        logic cmp_en;    // register the per-knob threshold hits
        logic load;      // load the output register with the current knob
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;       // current knob exceeded the threshold
        logic out_free;  // output register can take a word this cycle
    } t_sts;

endpackage

`default_nettype wire

@@ rtl/kwcd_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module kwcd_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/kwcd_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module kwcd_ctrl #(
    parameter int WINDOW_LEN = 5,
    parameter int KNOB_COUNT = 3,
    localparam int AW = $clog2(WINDOW_LEN),
    localparam int CW = $clog2(WINDOW_LEN + 1),
    localparam int KW = (KNOB_COUNT > 1) ? $clog2(KNOB_COUNT) : 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire kwcd_pkg::t_sts  i_sts,
    output kwcd_pkg::t_cmd       o_cmd,
    output logic      [AW-1:0]   o_wr_addr,
    output logic      [AW-1:0]   o_rd_addr,
    output logic      [KW-1:0]   o_knob
);

    import kwcd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_EMIT
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_pos,   n_pos;
    logic [CW-1:0]   r_cnt,   n_cnt;
    logic [KW-1:0]   r_knob,  n_knob;
    logic            accept;
    logic            wrap;
    logic            advance;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = o_in_ready && i_in_valid;
    assign wrap       = (r_pos == AW'(WINDOW_LEN - 1));
    // A knob without a hit is skipped at once; one with a hit waits for the output.
    assign advance    = !i_sts.hit || i_sts.out_free;

    always_comb begin
        o_cmd          = '0;
        o_cmd.wr_en    = accept;
        o_cmd.rd_en    = (r_state == S_READ) && (r_cnt < CW'(WINDOW_LEN));
        o_cmd.rd_first = (r_cnt == '0);
        o_cmd.cmp_en   = (r_state == S_CMP);
        o_cmd.load     = (r_state == S_EMIT) && i_sts.hit && i_sts.out_free;
        o_wr_addr      = r_pos;
        o_rd_addr      = r_cnt[AW-1:0];
        o_knob         = r_knob;
    end

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_cnt   = r_cnt;
        n_knob  = r_knob;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (wrap) begin
                        n_pos   = '0;
                        n_cnt   = '0;
                        n_state = S_READ;
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end
            end
            S_READ: begin
                // The last row's data is accumulated in the cycle after it is read.
                if (r_cnt == CW'(WINDOW_LEN)) begin
                    n_state = S_CMP;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_CMP: begin
                n_knob  = '0;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (advance) begin
                    if (r_knob == KW'(KNOB_COUNT - 1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_knob = r_knob + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
            r_cnt   <= '0;
            r_knob  <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_cnt   <= n_cnt;
            r_knob  <= n_knob;
        end
    end

`ifndef ASSERT_OFF
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.wr_en && o_cmd.rd_en))
        else $error("window write and read sweep overlap");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> i_sts.out_free)
        else $error("output register loaded while occupied");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= AW'(WINDOW_LEN - 1))
        else $error("window position out of range");

    a_wrap_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && wrap) |=> (!o_in_ready && r_pos == '0))
        else $error("wrap did not start the window reduction");
`endif

endmodule

`default_nettype wire

@@ rtl/kwcd_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module kwcd_dp #(
    parameter int WINDOW_LEN = 5,
    parameter int KNOB_COUNT = 3,
    localparam int AW = $clog2(WINDOW_LEN),
    localparam int KW = (KNOB_COUNT > 1) ? $clog2(KNOB_COUNT) : 1
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire kwcd_pkg::t_cmd                      i_cmd,
    input  wire logic      [AW-1:0]                  i_wr_addr,
    input  wire logic      [AW-1:0]                  i_rd_addr,
    input  wire logic      [KW-1:0]                  i_knob,
    input  wire logic      [kwcd_pkg::IN_TDATA_W-1:0] i_samples,
    input  wire logic                                i_cfg_valid,
    input  wire logic      [kwcd_pkg::SAMPLE_W-1:0]  i_cfg_data,
    output kwcd_pkg::t_sts                           o_sts,
    output logic           [kwcd_pkg::OUT_TDATA_W-1:0] o_tdata,
    output logic           [kwcd_pkg::KNOB_IDX_W-1:0]  o_tuser,
    output logic                                     o_tlast,
    output logic                                     o_tvalid,
    input  wire logic                                i_tready
);

    import kwcd_pkg::*;

    localparam int RW = SAMPLE_W * KNOB_COUNT;

    logic [RW-1:0]         wr_row;
    logic [RW-1:0]         rd_row;
    logic [SAMPLE_W-1:0]   r_acc  [KNOB_COUNT];
    logic [SAMPLE_W-1:0]   r_last [KNOB_COUNT];
    logic [KNOB_COUNT-1:0] r_hit, n_hit;
    logic [KNOB_COUNT-1:0] upper;
    logic [SAMPLE_W-1:0]   diff   [KNOB_COUNT];
    logic [SAMPLE_W-1:0]   r_thr;
    logic                  r_acc_en;
    logic                  r_acc_first;
    logic [SAMPLE_W-1:0]   r_oval;
    logic [KNOB_IDX_W-1:0] r_ouser;
    logic                  r_olast;
    logic                  r_ovalid;

    // One RAM row holds one poll round, all knobs side by side.
    assign wr_row = i_samples[RW-1:0];

    kwcd_ram #(
        .WIDTH (RW),
        .DEPTH (WINDOW_LEN)
    ) u_window (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (wr_row),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (rd_row)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_en    <= 1'b0;
            r_acc_first <= 1'b0;
        end else begin
            r_acc_en    <= i_cmd.rd_en;
            r_acc_first <= i_cmd.rd_en && i_cmd.rd_first;
        end
    end

    // Running halving average, one lane per knob.
    always_ff @(posedge i_clk) begin
        if (r_acc_en) begin
            for (int k = 0; k < KNOB_COUNT; k++) begin
                if (r_acc_first) begin
                    r_acc[k] <= rd_row[k*SAMPLE_W +: SAMPLE_W];
                end else begin
                    r_acc[k] <= SAMPLE_W'(({1'b0, r_acc[k]}
                                + {1'b0, rd_row[k*SAMPLE_W +: SAMPLE_W]}) >> 1);
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < KNOB_COUNT; k++) begin
            diff[k]  = (r_acc[k] >= r_last[k]) ? (r_acc[k] - r_last[k])
                                               : (r_last[k] - r_acc[k]);
            n_hit[k] = (diff[k] > r_thr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THRESH_RESET;
            r_hit <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
            if (i_cmd.cmp_en) begin
                r_hit <= n_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KNOB_COUNT; k++) begin
                r_last[k] <= '0;
            end
        end else if (i_cmd.load) begin
            r_last[i_knob] <= r_acc[i_knob];
        end
    end

    // The event is the round's last when no higher knob has a hit.
    assign upper = (r_hit >> i_knob) >> 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.load) begin
            r_ovalid <= 1'b1;
        end else if (i_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_oval  <= r_acc[i_knob];
            r_ouser <= KNOB_IDX_W'(i_knob);
            r_olast <= (upper == '0);
        end
    end

    assign o_sts.hit      = r_hit[i_knob];
    assign o_sts.out_free = !r_ovalid || i_tready;
    assign o_tdata        = OUT_TDATA_W'(r_oval);
    assign o_tuser        = r_ouser;
    assign o_tlast        = r_olast;
    assign o_tvalid       = r_ovalid;

endmodule

`default_nettype wire

@@ rtl/knob_window_change_detector.sv @@
`timescale 1ns / 1ps
`default_nettype none
// A round that does not complete the window is only written to the window RAM and gives no word.
// A round that completes it sweeps the window RAM one row per cycle; the word for knob k
// is loaded into the output register after the sweep, the compare and the lower knobs.
// Such a round holds s_axis_tready low through the sweep, the compare and each knob's word plus any
// output stall, set by the single read port of the window RAM and the one output register.
// Synchronous active-low reset clears the position and reported values and sets the threshold to 20.

module knob_window_change_detector #(
    parameter int WINDOW_LEN = 5,
    parameter int KNOB_COUNT = 3
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // sample_knob0, sample_knob1, sample_knob2, zero fill
    input  wire logic [kwcd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // averaged_value, zero fill
    output logic      [kwcd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // knob_index
    output logic      [kwcd_pkg::KNOB_IDX_W-1:0]      m_axis_tuser,
    output logic                                      m_axis_tlast,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [kwcd_pkg::SAMPLE_W-1:0]        i_cfg_data
);

    import kwcd_pkg::*;

    localparam int AW = $clog2(WINDOW_LEN);
    localparam int KW = (KNOB_COUNT > 1) ? $clog2(KNOB_COUNT) : 1;

    t_cmd          cmd;
    t_sts          sts;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [KW-1:0] knob;

    assign o_cfg_ready = 1'b1;

    kwcd_ctrl #(
        .WINDOW_LEN (WINDOW_LEN),
        .KNOB_COUNT (KNOB_COUNT)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_wr_addr  (wr_addr),
        .o_rd_addr  (rd_addr),
        .o_knob     (knob)
    );

    kwcd_dp #(
        .WINDOW_LEN (WINDOW_LEN),
        .KNOB_COUNT (KNOB_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_wr_addr   (wr_addr),
        .i_rd_addr   (rd_addr),
        .i_knob      (knob),
        .i_samples   (s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_sts       (sts),
        .o_tdata     (m_axis_tdata),
        .o_tuser     (m_axis_tuser),
        .o_tlast     (m_axis_tlast),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready)
    );

endmodule

`default_nettype wire
